### hdl/xeu_pkg.sv
`timescale 1ns / 1ps
// xeu_pkg: constants, entity name tables and shared types of the entity unescaper
// depends on nothing; used by every other file of the block but xeu_if

package xeu_pkg;

  localparam int NUM_ENT    = 5;   // predefined entities
  localparam int NAME_MAX   = 5;   // longest name including the semicolon
  localparam int HELD_DEPTH = 4;   // letters held after the ampersand
  localparam int MAX_OUT    = 6;   // bytes one input byte can give
  localparam int COUNT_W    = 3;   // holds 0 to MAX_OUT and 0 to HELD_DEPTH

  localparam logic [7:0] AMP_CHAR = 8'h26;

  typedef logic [7:0] byte_t;

  // names with their semicolon, padded with zero
  localparam byte_t ENT_NAME [NUM_ENT][NAME_MAX] = '{
    '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},   // amp;
    '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},   // quot;
    '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},   // apos;
    '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},   // lt;
    '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00}    // gt;
  };

  localparam logic [COUNT_W-1:0] ENT_LEN [NUM_ENT] = '{
    3'd4, 3'd5, 3'd5, 3'd3, 3'd3
  };

  localparam byte_t ENT_CHAR [NUM_ENT] = '{
    8'h26, 8'h22, 8'h27, 8'h3c, 8'h3e
  };

  // burst of result bytes for one input byte, first byte in element 0
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [COUNT_W-1:0]      cnt;
    logic                    last;
  } xeu_burst_t;

endpackage

### hdl/xeu_if.sv
`timescale 1ns / 1ps
// xeu_in_if and xeu_out_if: valid/ready channels of the entity unescaper
// standalone, no package needed

interface xeu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xeu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### hdl/xeu_match.sv
`timescale 1ns / 1ps
// xeu_match: match state and the per-byte matching logic that builds a burst
// depends on xeu_pkg

module xeu_match (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic [7:0]         byte_in,
  input  logic               last_in,
  output xeu_pkg::xeu_burst_t result
);

  logic                                     act_r, act_nxt;
  logic [xeu_pkg::COUNT_W-1:0]              cnt_r, cnt_nxt;
  logic [xeu_pkg::HELD_DEPTH-1:0][7:0]      held_r, held_nxt;

  always_comb begin
    logic [xeu_pkg::COUNT_W-1:0] n_out;
    logic                        hit;
    logic                        any_full;
    logic                        any_pre;
    logic                        do_fresh;
    logic [7:0]                  full_ch;

    result   = '0;
    n_out    = '0;
    act_nxt  = act_r;
    cnt_nxt  = cnt_r;
    held_nxt = held_r;
    any_full = 1'b0;
    any_pre  = 1'b0;
    do_fresh = 1'b0;
    full_ch  = '0;

    // compare held letters plus the new byte against every name
    for (int e = 0; e < xeu_pkg::NUM_ENT; e++) begin
      hit = xeu_pkg::ENT_LEN[e] > cnt_r;
      for (int k = 0; k < xeu_pkg::HELD_DEPTH; k++) begin
        if (xeu_pkg::COUNT_W'(k) < cnt_r && xeu_pkg::ENT_NAME[e][k] != held_r[k]) begin
          hit = 1'b0;
        end
      end
      if (xeu_pkg::ENT_NAME[e][cnt_r] != byte_in) begin
        hit = 1'b0;
      end
      if (hit) begin
        if (xeu_pkg::ENT_LEN[e] == cnt_r + 3'd1) begin
          any_full = 1'b1;
          full_ch  = xeu_pkg::ENT_CHAR[e];
        end else begin
          any_pre = 1'b1;
        end
      end
    end

    if (!act_r) begin
      do_fresh = 1'b1;
    end else if (any_full) begin
      result.bytes[n_out] = full_ch;
      n_out   = n_out + 3'd1;
      act_nxt = 1'b0;
      cnt_nxt = '0;
    end else if (any_pre) begin
      held_nxt[cnt_r[1:0]] = byte_in;
      cnt_nxt = cnt_r + 3'd1;
    end else begin
      // broken match: ampersand and held letters go out literally
      result.bytes[n_out] = xeu_pkg::AMP_CHAR;
      n_out = n_out + 3'd1;
      for (int k = 0; k < xeu_pkg::HELD_DEPTH; k++) begin
        if (xeu_pkg::COUNT_W'(k) < cnt_r) begin
          result.bytes[n_out] = held_r[k];
          n_out = n_out + 3'd1;
        end
      end
      act_nxt  = 1'b0;
      cnt_nxt  = '0;
      do_fresh = 1'b1;
    end

    if (do_fresh) begin
      if (byte_in == xeu_pkg::AMP_CHAR) begin
        act_nxt = 1'b1;
        cnt_nxt = '0;
      end else begin
        result.bytes[n_out] = byte_in;
        n_out = n_out + 3'd1;
      end
    end

    // end of text: flush whatever is still held
    if (last_in && act_nxt) begin
      result.bytes[n_out] = xeu_pkg::AMP_CHAR;
      n_out = n_out + 3'd1;
      for (int k = 0; k < xeu_pkg::HELD_DEPTH; k++) begin
        if (xeu_pkg::COUNT_W'(k) < cnt_nxt) begin
          result.bytes[n_out] = held_nxt[k];
          n_out = n_out + 3'd1;
        end
      end
      act_nxt = 1'b0;
      cnt_nxt = '0;
    end

    result.cnt  = n_out;
    result.last = last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else if (advance) begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      held_r <= held_nxt;
    end
  end

endmodule

### hdl/xeu_burst.sv
`timescale 1ns / 1ps
// xeu_burst: result register that plays out a burst one byte per transfer
// depends on xeu_pkg and xeu_out_if

module xeu_burst (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  xeu_pkg::xeu_burst_t burst,
  output logic                free,
  xeu_out_if.source           out_s
);

  logic [xeu_pkg::MAX_OUT-1:0][7:0] buf_r, buf_nxt;
  logic [xeu_pkg::COUNT_W-1:0]      cnt_r, cnt_nxt;
  logic                             last_r, last_nxt;
  logic                             take;

  assign out_s.valid    = cnt_r != '0;
  assign out_s.out_byte = buf_r[0];
  assign out_s.out_last = last_r && cnt_r == 3'd1;

  assign take = out_s.valid && out_s.ready;
  // empty, or the final byte leaves in this cycle
  assign free = cnt_r == '0 || (cnt_r == 3'd1 && out_s.ready);

  always_comb begin
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (load) begin
      buf_nxt  = burst.bytes;
      cnt_nxt  = burst.cnt;
      last_nxt = burst.last;
    end else if (take) begin
      buf_nxt = buf_r >> 8;
      cnt_nxt = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r  <= buf_nxt;
    last_r <= last_nxt;
  end

endmodule

### hdl/xml_entity_unescape.sv
`timescale 1ns / 1ps
// xml_entity_unescape: predefined xml entity unescaper, top level
// depends on xeu_pkg, xeu_if, xeu_match and xeu_burst
//
// Replaces &amp; &quot; &apos; &lt; &gt; in a byte stream with & " ' < >.
// Bytes after an ampersand are held while they still spell the start of a
// name; a byte that breaks the match sends the ampersand and held letters
// out literally and is then handled afresh, and in_last flushes anything
// still held, with out_last on the final byte of that item. An input byte
// passes an input register, the matching logic and a burst register, and the
// first result is offered from the burst register. One byte is taken per cycle
// as long as each gives at most one result and the output is ready; a byte
// that gives k results (up to six, on a broken match) holds the output while
// they go out, the output port's one byte per transfer being what sets the
// rate, and a byte that is only held gives nothing.

module xml_entity_unescape (
  input  logic      clk,
  input  logic      rst_n,
  xeu_in_if.sink    in_s,
  xeu_out_if.source out_s
);

  // input register
  logic       a_valid_r, a_valid_nxt;
  logic [7:0] a_byte_r;
  logic       a_last_r;

  logic                free;
  logic                advance;
  logic                load;
  xeu_pkg::xeu_burst_t burst;

  // item moves on when the burst register is empty or draining its last byte
  assign advance   = a_valid_r && free;
  assign in_s.ready = !a_valid_r || free;
  // a held byte gives nothing, so the burst register is left alone
  assign load      = advance && burst.cnt != '0;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_s.valid && in_s.ready) begin
      a_valid_nxt = 1'b1;
    end else if (advance) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  // payload captured on every input transfer
  always_ff @(posedge clk) begin
    if (in_s.valid && in_s.ready) begin
      a_byte_r <= in_s.in_byte;
      a_last_r <= in_s.in_last;
    end
  end

  // match state and burst building
  xeu_match u_match (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_in (a_byte_r),
    .last_in (a_last_r),
    .result  (burst)
  );

  // result register, one byte per output transfer
  xeu_burst u_burst (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .burst (burst),
    .free  (free),
    .out_s (out_s)
  );

endmodule

### tb/xeu_checker.sv
`timescale 1ns / 1ps
// xeu_checker: watches both channels of the entity unescaper, predicts the output bytes
// depends on xeu_pkg and xeu_if

module xeu_checker (
  input  logic clk,
  input  logic rst_n,
  xeu_in_if    in_mon,
  xeu_out_if   out_mon,
  output int   error_count,
  output int   expected_left
);

  localparam int N_ENT = 5;

  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_LT   = 8'h3c;
  localparam logic [7:0] CH_GT   = 8'h3e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  string      ent_name [N_ENT] = '{"amp;", "quot;", "apos;", "lt;", "gt;"};
  logic [7:0] ent_char [N_ENT] = '{xeu_pkg::AMP_CHAR, CH_QUOT, CH_APOS, CH_LT, CH_GT};

  text_byte_t  expected_q [$];
  logic        amp_open = 1'b0;
  int          held_n = 0;
  logic [7:0]  held_letters [xeu_pkg::HELD_DEPTH];
  int          step_results;
  int          errors = 0;

  function automatic void put_byte(input logic [7:0] b);
    text_byte_t t;
    t.data = b;
    t.last = 1'b0;
    expected_q.push_back(t);
    step_results++;
  endfunction

  // ampersand and held letters go out as they came
  function automatic void flush_literal();
    put_byte(xeu_pkg::AMP_CHAR);
    for (int k = 0; k < held_n; k++) put_byte(held_letters[k]);
    amp_open = 1'b0;
    held_n = 0;
  endfunction

  function automatic void take_fresh(input logic [7:0] b);
    if (b == xeu_pkg::AMP_CHAR) begin
      amp_open = 1'b1;
      held_n = 0;
    end else begin
      put_byte(b);
    end
  endfunction

  function automatic void match_byte(input logic [7:0] b);
    logic [7:0] cand [xeu_pkg::HELD_DEPTH+1];
    logic [7:0] c;
    int         n;
    bit         partial;
    bit         hit;
    if (!amp_open) begin
      take_fresh(b);
      return;
    end
    n = held_n;
    for (int i = 0; i < n; i++) cand[i] = held_letters[i];
    cand[n] = b;
    partial = 1'b0;
    for (int e = 0; e < N_ENT; e++) begin
      if (ent_name[e].len() >= n + 1) begin
        hit = 1'b1;
        for (int i = 0; i <= n; i++) begin
          c = ent_name[e][i];
          if (c != cand[i]) hit = 1'b0;
        end
        if (hit) begin
          if (ent_name[e].len() == n + 1) begin
            put_byte(ent_char[e]);
            amp_open = 1'b0;
            held_n = 0;
            return;
          end
          partial = 1'b1;
        end
      end
    end
    if (partial && n < xeu_pkg::HELD_DEPTH) begin
      held_letters[n] = b;
      held_n = n + 1;
      return;
    end
    flush_literal();
    take_fresh(b);
  endfunction

  function automatic void unescape_step(input logic [7:0] b, input logic last);
    step_results = 0;
    match_byte(b);
    if (last) begin
      if (amp_open) flush_literal();
      if (step_results > 0) expected_q[expected_q.size()-1].last = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    text_byte_t want;
    if (!rst_n) begin
      amp_open = 1'b0;
      held_n = 0;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected transfer: out_byte %02h out_last %0b",
                 out_mon.out_byte, out_mon.out_last);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_mon.out_byte);
            errors++;
          end
          if (out_mon.out_last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_mon.out_last);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) unescape_step(in_mon.in_byte, in_mon.in_last);
    end
    error_count   <= errors;
    expected_left <= expected_q.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// tb: stimulus and verdict for the xml entity unescaper
// depends on xeu_pkg, xeu_if, xml_entity_unescape and xeu_checker

module tb;

  localparam int RAND_ITEMS   = 333;
  localparam int PHASES       = 3;
  localparam int DRAIN_LIMIT  = 20000;  // cycles allowed for the last results
  localparam int SETTLE_WAIT  = 12;     // settling wait after the drain

  logic        clk;
  logic        rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          items_sent;
  int          error_count;
  int          expected_left;

  xeu_in_if  in_ch ();
  xeu_out_if out_ch ();

  xml_entity_unescape dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_s (out_ch)
  );

  xeu_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .error_count   (error_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("[xml_entity_unescape] ERROR");
    $finish;
  end

  // receiver: drops ready at random, rate set by the current phase
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // one byte per transfer, with random idle cycles before it
  task automatic send_item(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    // ready is read before the edge's updates land, so this is the sampled value
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit last_on_end);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      send_item(c, last_on_end && (i == s.len() - 1));
    end
  endtask

  // end of text mostly at segment ends, now and then in the middle of one
  function automatic logic pick_last(input bit at_end, input bit seg_last);
    return (at_end && seg_last) || ($urandom_range(24) == 0);
  endfunction

  // one random piece of text: half well-formed entities, the rest broken or plain
  task automatic send_segment();
    int unsigned kind;
    int unsigned ent;
    int unsigned len;
    int unsigned cut;
    int unsigned n_plain;
    bit          seg_last;
    kind     = $urandom_range(9);
    ent      = $urandom_range(xeu_pkg::NUM_ENT - 1);
    len      = xeu_pkg::ENT_LEN[ent];
    cut      = $urandom_range(len - 1);
    seg_last = ($urandom_range(5) == 0);
    case (kind)
      0, 1, 2, 3, 4: begin
        // complete entity
        send_item(xeu_pkg::AMP_CHAR, pick_last(0, seg_last));
        for (int i = 0; i < len; i++)
          send_item(xeu_pkg::ENT_NAME[ent][i], pick_last(i == len - 1, seg_last));
      end
      5, 6: begin
        // name cut short, then any byte
        send_item(xeu_pkg::AMP_CHAR, pick_last(0, seg_last));
        for (int i = 0; i < cut; i++)
          send_item(xeu_pkg::ENT_NAME[ent][i], pick_last(0, seg_last));
        send_item(8'($urandom_range(255)), pick_last(1, seg_last));
      end
      7: begin
        // a fresh ampersand breaks the open match
        send_item(xeu_pkg::AMP_CHAR, pick_last(0, seg_last));
        for (int i = 0; i < cut; i++)
          send_item(xeu_pkg::ENT_NAME[ent][i], pick_last(0, seg_last));
        send_item(xeu_pkg::AMP_CHAR, pick_last(1, seg_last));
      end
      8: begin
        n_plain = $urandom_range(1, 4);
        for (int i = 0; i < n_plain; i++)
          send_item(8'($urandom_range(255)), pick_last(i == n_plain - 1, seg_last));
      end
      default: begin
        // random letter inside a name
        send_item(xeu_pkg::AMP_CHAR, pick_last(0, seg_last));
        for (int i = 0; i < cut; i++)
          send_item(xeu_pkg::ENT_NAME[ent][i], pick_last(0, seg_last));
        send_item(8'($urandom_range(8'h61, 8'h7a)), pick_last(1, seg_last));
      end
    endcase
  endtask

  initial begin
    int phase_end;
    int waited;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 81;
    items_sent    = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every entity, ampersand while matching, broken name,
    // byte extremes, end of text on plain byte, on a closing semicolon,
    // on an open match and on a lone ampersand
    send_item(8'h00, 1'b0);
    send_text("&&amp;&quot;&apos;&lt;", 1'b0);
    send_text("&gt;", 1'b1);
    send_text("&quo", 1'b0);
    send_item(8'hff, 1'b0);
    send_item(8'h00, 1'b1);
    send_text("&ap", 1'b1);
    send_text("&", 1'b1);

    // random text, three idling regimes
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 81;
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_end = items_sent + RAND_ITEMS / PHASES;
      while (items_sent < phase_end) send_segment();
    end
    // close the text so nothing stays held
    send_item(8'($urandom_range(255)), 1'b1);
    in_ch.valid <= 1'b0;
    @(posedge clk);

    waited = 0;
    while (expected_left != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // catch any stray transfer after the last expected one
    repeat (SETTLE_WAIT) @(posedge clk);

    if (error_count == 0 && expected_left == 0) begin
      $display("[xml_entity_unescape] OK");
    end else begin
      $display("[xml_entity_unescape] ERROR");
    end
    $finish;
  end

endmodule
